// ===== rtl/gbpe_pkg.sv =====
// Shared types and constants for the glyph bitmap pixel expander.
package gbpe_pkg;

	localparam int COORD_W = 12;
	localparam int COLOR_W = 24;
	localparam int PITCH_W = 8;
	localparam int BPP_W   = 4;

	// Screen limit: a write at or beyond this column or row is dropped.
	localparam int SCREEN_SPAN = 4096;
	localparam int PIX_LIM_I   = (SCREEN_SPAN < 4096) ? SCREEN_SPAN : 4096;
	localparam logic [COORD_W:0] PIX_LIM = (COORD_W + 1)'(PIX_LIM_I);

	localparam int BOLD_COPIES = 3;
	localparam int TOP_BIT     = 7;

	localparam logic OP_START = 1'b0;
	localparam logic OP_DATA  = 1'b1;

	localparam logic [BPP_W-1:0] BPP_MONO = 4'd1;
	localparam logic [BPP_W-1:0] BPP_WIDE = 4'd8;

	localparam logic REG_FONT_MODE  = 1'b0;
	localparam logic REG_FONT_COLOR = 1'b1;

	localparam int MODE_BOLD  = 0;
	localparam int MODE_ULINE = 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH,
		ST_ERR
	} state_t;

	typedef struct packed {
		logic load_start;
		logic load_data;
		logic step;
		logic push_err;
		logic push_last;
	} dp_cmd_t;

	typedef struct packed {
		logic live;
		logic fmt_bad;
		logic cand_ok;
		logic scan_end;
		logic hold_full;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== rtl/gbpe_ctrl.sv =====
// Controller state machine: sequences start, scan, flush and error beats.
module gbpe_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               opcode,
	input  gbpe_pkg::dp_stat_t stat,
	output logic               in_ready,
	output gbpe_pkg::dp_cmd_t  cmd
);
	import gbpe_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   stall;

	// Scan must wait when a found pixel would push the held one into a full output.
	assign stall = stat.cand_ok && stat.hold_full && !stat.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (opcode == OP_START) begin
						if (stat.fmt_bad) state_d = ST_ERR;
					end else if (stat.live) begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (!stall && stat.scan_end) state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (!stat.hold_full || stat.out_free) state_d = ST_IDLE;
			end
			ST_ERR: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (opcode == OP_START) cmd.load_start = 1'b1;
					else if (stat.live) cmd.load_data = 1'b1;
				end
			end
			ST_SCAN: begin
				cmd.step = !stall;
			end
			ST_FLUSH: begin
				cmd.push_last = stat.hold_full && stat.out_free;
			end
			ST_ERR: begin
				cmd.push_err = stat.out_free;
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/gbpe_dp.sv =====
// Datapath: font registers, glyph geometry, pixel candidate unit and output register.
module gbpe_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  gbpe_pkg::dp_cmd_t                 cmd,
	output gbpe_pkg::dp_stat_t                stat,
	input  logic                              cfg_valid,
	input  logic                              cfg_index,
	input  logic [gbpe_pkg::COLOR_W-1:0]      cfg_data,
	input  logic [gbpe_pkg::COORD_W-1:0]      box_left,
	input  logic [gbpe_pkg::COORD_W-1:0]      box_right,
	input  logic [gbpe_pkg::COORD_W-1:0]      box_top,
	input  logic [gbpe_pkg::COORD_W-1:0]      box_bottom,
	input  logic [gbpe_pkg::PITCH_W-1:0]      row_pitch,
	input  logic [gbpe_pkg::BPP_W-1:0]        bits_per_pixel,
	input  logic [7:0]                        data_byte,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [gbpe_pkg::COORD_W-1:0]      pixel_x,
	output logic [gbpe_pkg::COORD_W-1:0]      pixel_y,
	output logic [gbpe_pkg::COLOR_W-1:0]      pixel_color,
	output logic                              format_error,
	output logic                              last
);
	import gbpe_pkg::*;

	logic [1:0]         font_mode_q;
	logic [COLOR_W-1:0] font_color_q;

	logic [COORD_W-1:0] left_q, right_q, top_q, bottom_q;
	logic [PITCH_W-1:0] pitch_q;
	logic               wide_q;
	logic               bad_q;
	logic [COORD_W-1:0] row_q;
	logic [PITCH_W-1:0] bir_q;

	logic [7:0]         byte_q;
	logic [PITCH_W-1:0] base_q;
	logic [COORD_W:0]   y_q;
	logic               ul_q;
	logic [2:0]         k_q;
	logic [1:0]         c_q;

	logic [COORD_W-1:0] hold_x_q;
	logic               hold_full_q;

	logic               out_valid_q;
	logic [COORD_W-1:0] pixel_x_q, pixel_y_q;
	logic [COLOR_W-1:0] pixel_color_q;
	logic               err_q;
	logic               last_q;

	logic [COORD_W:0]   row_y;
	logic [PITCH_W-1:0] bir_inc;
	logic [10:0]        off;
	logic               ink;
	logic [COORD_W:0]   x0;
	logic [COORD_W:0]   x;
	logic               cand_ok;
	logic [1:0]         last_c;
	logic               out_free;
	logic               push_hold;

	assign row_y   = {1'b0, top_q} + {1'b0, row_q};
	assign bir_inc = bir_q + 1'b1;

	assign off    = wide_q ? {3'b000, base_q} : {base_q, k_q};
	assign ink    = wide_q ? (|byte_q) : byte_q[3'(TOP_BIT) - k_q];
	assign x0     = {1'b0, left_q} + {2'b00, off};
	assign x      = x0 + {{(COORD_W-1){1'b0}}, c_q};
	assign last_c = font_mode_q[MODE_BOLD] ? 2'(BOLD_COPIES - 1) : 2'd0;

	// Covered by the row width, on screen, and inked or underlined.
	assign cand_ok = (ink || ul_q) && (x0 < {1'b0, right_q}) && (x < PIX_LIM) && (y_q < PIX_LIM);

	assign out_free  = !out_valid_q || out_ready;
	assign push_hold = cmd.step && cand_ok && hold_full_q;

	always_comb begin
		stat.live      = !bad_q && (row_y < {1'b0, bottom_q});
		stat.fmt_bad   = !(bits_per_pixel == BPP_MONO || bits_per_pixel == BPP_WIDE);
		stat.cand_ok   = cand_ok;
		stat.scan_end  = (wide_q || k_q == 3'(TOP_BIT)) && (c_q == last_c);
		stat.hold_full = hold_full_q;
		stat.out_free  = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			font_mode_q  <= '0;
			font_color_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FONT_MODE:  font_mode_q  <= cfg_data[1:0];
				REG_FONT_COLOR: font_color_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Glyph geometry and the row walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			right_q  <= '0;
			top_q    <= '0;
			bottom_q <= '0;
			pitch_q  <= '0;
			wide_q   <= 1'b0;
			bad_q    <= 1'b0;
			row_q    <= '0;
			bir_q    <= '0;
		end else if (cmd.load_start) begin
			left_q   <= box_left;
			right_q  <= box_right;
			top_q    <= box_top;
			bottom_q <= box_bottom;
			pitch_q  <= row_pitch;
			wide_q   <= (bits_per_pixel == BPP_WIDE);
			bad_q    <= stat.fmt_bad;
			row_q    <= '0;
			bir_q    <= '0;
		end else if (cmd.load_data) begin
			// A pitch of zero wraps after 256 bytes.
			if (bir_inc == pitch_q) begin
				bir_q <= '0;
				row_q <= row_q + 1'b1;
			end else begin
				bir_q <= bir_inc;
			end
		end
	end

	// Capture the byte and its row context; step through pixels and copies.
	always_ff @(posedge clk) begin
		if (cmd.load_data) begin
			byte_q <= data_byte;
			base_q <= bir_q;
			y_q    <= row_y;
			ul_q   <= font_mode_q[MODE_ULINE] && (row_y + 1'b1 == {1'b0, bottom_q});
			k_q    <= '0;
			c_q    <= '0;
		end else if (cmd.step) begin
			if (c_q == last_c) begin
				c_q <= '0;
				k_q <= k_q + 1'b1;
			end else begin
				c_q <= c_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_full_q <= 1'b0;
		end else if (cmd.step && cand_ok) begin
			hold_full_q <= 1'b1;
		end else if (cmd.push_last) begin
			hold_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step && cand_ok) hold_x_q <= x[COORD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push_hold || cmd.push_last || cmd.push_err) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_err) begin
			pixel_x_q     <= '0;
			pixel_y_q     <= '0;
			pixel_color_q <= '0;
			err_q         <= 1'b1;
			last_q        <= 1'b1;
		end else if (push_hold || cmd.push_last) begin
			pixel_x_q     <= hold_x_q;
			pixel_y_q     <= y_q[COORD_W-1:0];
			pixel_color_q <= font_color_q;
			err_q         <= 1'b0;
			last_q        <= cmd.push_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign pixel_x      = pixel_x_q;
	assign pixel_y      = pixel_y_q;
	assign pixel_color  = pixel_color_q;
	assign format_error = err_q;
	assign last         = last_q;

`ifndef ASSERT_OFF
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load_start, cmd.load_data, cmd.step, cmd.push_err, cmd.push_last}))
		else $error("datapath commands overlap");

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		(push_hold || cmd.push_last || cmd.push_err) |-> out_free)
		else $error("output beat overwritten before it was taken");

	a_last_held: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_last |-> hold_full_q)
		else $error("final pixel pushed from an empty hold register");

	a_new_byte_clean: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_data |-> !hold_full_q)
		else $error("pixel from previous byte still held");

	a_err_beat: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_err |=> (out_valid_q && err_q && last_q && pixel_color_q == '0))
		else $error("error beat malformed");
`endif

endmodule

// ===== rtl/glyph_bitmap_pixel_expander.sv =====
// Top level of the glyph bitmap pixel expander: controller plus datapath.
//
//  channel | valid     | ready     | payload
//  --------+-----------+-----------+-------------------------------------------------
//  in      | in_valid  | in_ready  | opcode, box_*, row_pitch, bits_per_pixel, data_byte
//  out     | out_valid | out_ready | pixel_x, pixel_y, pixel_color, format_error, last
//  cfg     | cfg_valid | cfg_ready | cfg_index, cfg_data
//
// A start beat loads the glyph box; a bad format then adds an error beat.
// A data beat scans copies copies of each of 8 pixels for 1 bpp (copies is 3 in bold, else 1)
// and of one pixel for 8 bpp; the candidate unit tests one pixel copy per cycle unless stalled.
// A full output register stalls the scan; the next input beat waits until the scan ends.
// Reset clears font registers, glyph box, state and valid flags; no clearing pass.
module glyph_bitmap_pixel_expander (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         cfg_index,
	input  logic [gbpe_pkg::COLOR_W-1:0] cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         opcode,
	input  logic [gbpe_pkg::COORD_W-1:0] box_left,
	input  logic [gbpe_pkg::COORD_W-1:0] box_right,
	input  logic [gbpe_pkg::COORD_W-1:0] box_top,
	input  logic [gbpe_pkg::COORD_W-1:0] box_bottom,
	input  logic [gbpe_pkg::PITCH_W-1:0] row_pitch,
	input  logic [gbpe_pkg::BPP_W-1:0]   bits_per_pixel,
	input  logic [7:0]                   data_byte,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [gbpe_pkg::COORD_W-1:0] pixel_x,
	output logic [gbpe_pkg::COORD_W-1:0] pixel_y,
	output logic [gbpe_pkg::COLOR_W-1:0] pixel_color,
	output logic                         format_error,
	output logic                         last
);
	import gbpe_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Registers are plain flops: take every write at once.
	assign cfg_ready = 1'b1;

	gbpe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (opcode),
		.stat     (stat),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	gbpe_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.box_left       (box_left),
		.box_right      (box_right),
		.box_top        (box_top),
		.box_bottom     (box_bottom),
		.row_pitch      (row_pitch),
		.bits_per_pixel (bits_per_pixel),
		.data_byte      (data_byte),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.pixel_x        (pixel_x),
		.pixel_y        (pixel_y),
		.pixel_color    (pixel_color),
		.format_error   (format_error),
		.last           (last)
	);

endmodule
